// ===== hdl/jsu_pkg.sv =====
// ---------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescape / UTF-8 unit.
// ---------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_BYTE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

    // Command passed from the parser to the byte emitter
    typedef enum logic [1:0] {
        CMD_RAW   = 2'd0,   // one byte as is
        CMD_CP    = 2'd1,   // code point, UTF-8 encoded
        CMD_DONE  = 2'd2,
        CMD_ERROR = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [20:0] cp;
    } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/jsu_front.sv =====
// ---------------------------------------------------------------------------
// jsu_front
// Parser: walks the string literal syntax one byte per cycle while accept is
// high and issues one command per byte that produces output.
// ---------------------------------------------------------------------------
`default_nettype none

module jsu_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   data_byte,
    input  wire logic         input_end,
    output jsu_pkg::cmd_t     cmd,
    output logic              cmd_push
);
    import jsu_pkg::*;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_STR    = 7'b0000010,
        PH_ESC    = 7'b0000100,
        PH_HEX1   = 7'b0001000,
        PH_NEEDBS = 7'b0010000,
        PH_NEEDU  = 7'b0100000,
        PH_HEX2   = 7'b1000000
    } phase_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    phase_t      phase_reg, phase_next;
    logic [15:0] first_unit_reg, first_unit_next;
    logic [15:0] second_unit_reg, second_unit_next;
    logic [1:0]  hex_count_reg, hex_count_next;

    logic        hex_ok;
    logic [3:0]  hex_val;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (data_byte >= 8'h30 && data_byte <= 8'h39)
        begin
            hex_val = data_byte[3:0];
        end
        else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
                 (data_byte >= 8'h41 && data_byte <= 8'h46))
        begin
            hex_val = data_byte[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        first_unit_next  = first_unit_reg;
        second_unit_next = second_unit_reg;
        hex_count_next   = hex_count_reg;
        cmd_push         = 1'b0;
        cmd.kind         = CMD_RAW;
        cmd.cp           = {13'd0, data_byte};

        if (accept)
        begin
            if (input_end)
            begin
                phase_next     = PH_IDLE;
                hex_count_next = 2'd0;
                cmd_push       = 1'b1;
                cmd.kind       = CMD_ERROR;
            end
            else
            begin
                unique case (phase_reg)
                    PH_STR:
                    begin
                        if (data_byte == CH_QUOTE)
                        begin
                            phase_next     = PH_IDLE;
                            hex_count_next = 2'd0;
                            cmd_push       = 1'b1;
                            cmd.kind       = CMD_DONE;
                        end
                        else if (data_byte == CH_BSLASH)
                        begin
                            phase_next = PH_ESC;
                        end
                        else
                        begin
                            cmd_push = 1'b1;
                        end
                    end
                    PH_ESC:
                    begin
                        phase_next = PH_STR;
                        cmd_push   = 1'b1;
                        case (data_byte)
                            CH_QUOTE, CH_BSLASH, CH_SLASH: ;
                            CH_B: cmd.cp = 21'h08;
                            CH_F: cmd.cp = 21'h0C;
                            CH_N: cmd.cp = 21'h0A;
                            CH_R: cmd.cp = 21'h0D;
                            CH_T: cmd.cp = 21'h09;
                            CH_U:
                            begin
                                phase_next      = PH_HEX1;
                                first_unit_next = 16'd0;
                                hex_count_next  = 2'd0;
                                cmd_push        = 1'b0;
                            end
                            default:
                            begin
                                phase_next     = PH_IDLE;
                                hex_count_next = 2'd0;
                                cmd.kind       = CMD_ERROR;
                            end
                        endcase
                    end
                    PH_HEX1:
                    begin
                        if (!hex_ok)
                        begin
                            phase_next     = PH_IDLE;
                            hex_count_next = 2'd0;
                            cmd_push       = 1'b1;
                            cmd.kind       = CMD_ERROR;
                        end
                        else
                        begin
                            first_unit_next = {first_unit_reg[11:0], hex_val};
                            if (hex_count_reg != 2'd3)
                            begin
                                hex_count_next = hex_count_reg + 2'd1;
                            end
                            else
                            begin
                                hex_count_next = 2'd0;
                                if (first_unit_next >= 16'hD800 &&
                                    first_unit_next <= 16'hDBFF)
                                begin
                                    phase_next = PH_NEEDBS;
                                end
                                else
                                begin
                                    phase_next = PH_STR;
                                    cmd_push   = 1'b1;
                                    cmd.kind   = CMD_CP;
                                    cmd.cp     = {5'd0, first_unit_next};
                                end
                            end
                        end
                    end
                    PH_NEEDBS:
                    begin
                        if (data_byte == CH_BSLASH)
                        begin
                            phase_next = PH_NEEDU;
                        end
                        else
                        begin
                            phase_next     = PH_IDLE;
                            hex_count_next = 2'd0;
                            cmd_push       = 1'b1;
                            cmd.kind       = CMD_ERROR;
                        end
                    end
                    PH_NEEDU:
                    begin
                        if (data_byte == CH_U)
                        begin
                            phase_next       = PH_HEX2;
                            second_unit_next = 16'd0;
                            hex_count_next   = 2'd0;
                        end
                        else
                        begin
                            phase_next     = PH_IDLE;
                            hex_count_next = 2'd0;
                            cmd_push       = 1'b1;
                            cmd.kind       = CMD_ERROR;
                        end
                    end
                    PH_HEX2:
                    begin
                        if (!hex_ok)
                        begin
                            phase_next     = PH_IDLE;
                            hex_count_next = 2'd0;
                            cmd_push       = 1'b1;
                            cmd.kind       = CMD_ERROR;
                        end
                        else
                        begin
                            second_unit_next = {second_unit_reg[11:0], hex_val};
                            if (hex_count_reg != 2'd3)
                            begin
                                hex_count_next = hex_count_reg + 2'd1;
                            end
                            else
                            begin
                                hex_count_next = 2'd0;
                                cmd_push       = 1'b1;
                                if (second_unit_next >= 16'hDC00 &&
                                    second_unit_next <= 16'hDFFF)
                                begin
                                    // join the pair: 0x10000 + high[9:0]:low[9:0]
                                    phase_next = PH_STR;
                                    cmd.kind   = CMD_CP;
                                    cmd.cp     = 21'h10000 +
                                        {1'b0, first_unit_reg[9:0], second_unit_next[9:0]};
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                    cmd.kind   = CMD_ERROR;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        // idle, and any stray phase code
                        phase_next = PH_IDLE;
                        if (data_byte == CH_QUOTE)
                        begin
                            phase_next = PH_STR;
                        end
                        else if (data_byte != CH_SPACE && data_byte != CH_TAB &&
                                 data_byte != CH_LF && data_byte != CH_CR)
                        begin
                            hex_count_next = 2'd0;
                            cmd_push       = 1'b1;
                            cmd.kind       = CMD_ERROR;
                        end
                    end
                endcase
            end
        end
        if (cmd.kind == CMD_DONE || cmd.kind == CMD_ERROR)
        begin
            cmd.cp = 21'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            first_unit_reg  <= 16'd0;
            second_unit_reg <= 16'd0;
            hex_count_reg   <= 2'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            first_unit_reg  <= first_unit_next;
            second_unit_reg <= second_unit_next;
            hex_count_reg   <= hex_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/jsu_cmd_queue.sv =====
// ---------------------------------------------------------------------------
// jsu_cmd_queue
// Small register FIFO of commands between parser and byte emitter.
// ---------------------------------------------------------------------------
`default_nettype none

module jsu_cmd_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire jsu_pkg::cmd_t wr_data,
    input  wire logic          rd_en,
    output jsu_pkg::cmd_t      rd_data,
    output logic               rd_valid,
    output logic               full
);
    import jsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign rd_valid = (count_reg != '0);
    assign full     = (count_reg == FULL_CNT);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/jsu_back.sv =====
// ---------------------------------------------------------------------------
// jsu_back
// Byte emitter: holds one command and hands out its bytes (UTF-8 encoded
// for code points), one per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module jsu_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire jsu_pkg::cmd_t  q_data,
    input  wire logic           q_valid,
    output logic                q_pop,
    input  wire logic           pop,
    output logic                empty,
    output logic [7:0]          out_byte,
    output logic [jsu_pkg::STATUS_W-1:0] status,
    output logic                last
);
    import jsu_pkg::*;

    logic       cur_valid_reg, cur_valid_next;
    cmd_t       cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;

    logic [1:0] final_idx;
    logic [7:0] enc_byte [4];
    logic [20:0] cp;

    assign cp = cur_reg.cp;

    always_comb
    begin
        enc_byte[0] = cp[7:0];
        enc_byte[1] = 8'h00;
        enc_byte[2] = 8'h00;
        enc_byte[3] = 8'h00;
        final_idx   = 2'd0;
        status      = ST_BYTE;
        unique case (cur_reg.kind)
            CMD_CP:
            begin
                if (cp <= 21'h7F)
                begin
                    final_idx = 2'd0;
                end
                else if (cp <= 21'h7FF)
                begin
                    final_idx   = 2'd1;
                    enc_byte[0] = 8'hC0 | {3'd0, cp[10:6]};
                    enc_byte[1] = 8'h80 | {2'd0, cp[5:0]};
                end
                else if (cp <= 21'hFFFF)
                begin
                    final_idx   = 2'd2;
                    enc_byte[0] = 8'hE0 | {4'd0, cp[15:12]};
                    enc_byte[1] = 8'h80 | {2'd0, cp[11:6]};
                    enc_byte[2] = 8'h80 | {2'd0, cp[5:0]};
                end
                else
                begin
                    final_idx   = 2'd3;
                    enc_byte[0] = 8'hF0 | {5'd0, cp[20:18]};
                    enc_byte[1] = 8'h80 | {2'd0, cp[17:12]};
                    enc_byte[2] = 8'h80 | {2'd0, cp[11:6]};
                    enc_byte[3] = 8'h80 | {2'd0, cp[5:0]};
                end
            end
            CMD_DONE:  status = ST_DONE;
            CMD_ERROR: status = ST_ERROR;
            default:   ;
        endcase
    end

    assign empty    = !cur_valid_reg;
    assign out_byte = enc_byte[idx_reg];
    assign last     = (idx_reg == final_idx);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        q_pop          = 1'b0;
        if (!cur_valid_reg || (pop && last))
        begin
            // take the next command, or go empty
            q_pop          = q_valid;
            cur_valid_next = q_valid;
            cur_next       = q_data;
            idx_next       = 2'd0;
        end
        else if (pop)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

`default_nettype wire

// ===== hdl/json_string_unescape_utf8_unit.sv =====
// ---------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// Streaming decoder for one JSON string literal to UTF-8 bytes.
// ---------------------------------------------------------------------------
// Input side is a queue write port: an item (data_byte, input_end) transfers
// on a clock edge with push high and full low. The parser handles one item
// per cycle and turns it into zero or one command, which goes into a short
// command queue (QUEUE_DEPTH entries).
// Result side is a queue read port: while empty is low the oldest result
// (out_byte, status, last) is on the ports and transfers when pop is high.
// A code point expands to one to four results, one per cycle; done and error
// are one result each. last marks the final result of an input item.
// A result passes through the command queue and the emitter's command
// register before it is visible. Throughput: one input item per cycle and
// one result per cycle while pop is high; full rises only while the consumer
// stalls or multi-byte code points drain slower than items arrive.
// A stalled consumer holds the current result; the queue absorbs new
// commands until full. Reset empties the queue and returns the parser to
// idle, waiting for an opening quote.
// ---------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_unit #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        input_end,
    input  wire logic        pop,
    output logic             empty,
    output logic [7:0]       out_byte,
    output logic [jsu_pkg::STATUS_W-1:0] status,
    output logic             last
);
    import jsu_pkg::*;

    cmd_t front_cmd;
    logic front_push;
    cmd_t q_data;
    logic q_valid;
    logic q_pop;
    logic accept;

    assign accept = push && !full;

    jsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .input_end (input_end),
        .cmd       (front_cmd),
        .cmd_push  (front_push)
    );

    jsu_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_push),
        .wr_data  (front_cmd),
        .rd_en    (q_pop),
        .rd_data  (q_data),
        .rd_valid (q_valid),
        .full     (full)
    );

    jsu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_byte (out_byte),
        .status   (status),
        .last     (last)
    );

endmodule

`default_nettype wire

// ===== hdl/jsu_checker.sv =====
// ---------------------------------------------------------------------------
// jsu_checker
// Port-level assertions for json_string_unescape_utf8_unit.
// ---------------------------------------------------------------------------
`default_nettype none

module jsu_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic        pop,
    input  wire logic        empty,
    input  wire logic [7:0]  out_byte,
    input  wire logic [jsu_pkg::STATUS_W-1:0] status,
    input  wire logic        last
);
    import jsu_pkg::*;

    // status codes are only byte, done or error
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == ST_BYTE || status == ST_DONE || status == ST_ERROR))
        else $error("status carries an unused code");

    // done and error are single results with a zero byte
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_BYTE) |-> (last && out_byte == 8'h00))
        else $error("done/error result not final or byte not zero");

    // nothing appears from an idle block without an input transfer;
    // a command already written to the queue still reaches the ports
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        (!(push && !full) ##1 empty) |=> empty)
        else $error("result appeared without an input transfer");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(out_byte) && $stable(status) && $stable(last)))
        else $error("stalled result changed");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (.*);

`default_nettype wire

// ===== sim/json_string_unescape_utf8_unit_tb.sv =====
// ---------------------------------------------------------------------------
// json_string_unescape_utf8_unit_tb
// Self-checking bench for the JSON string unescape / UTF-8 unit. A directed
// table covers whitespace, idle faults, raw extremes, a surrogate pair and
// the bad-digit, unknown-escape and end-of-input errors. A random stream of
// mostly well-formed string literals follows, with injected faults. Every
// input transfer runs through a local decoder; its results, or a row's typed
// expectation, are compared with the results popped from the unit.
// ---------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int RANDOM_ITEMS = 230;
    localparam int STALL_LIMIT  = 1000;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef enum logic [3:0] {
        P_IDLE, P_STR, P_ESC, P_HEX1, P_NEEDBS, P_NEEDU, P_HEX2
    } scan_phase_t;

    // How a row's expectation is formed
    typedef enum logic [1:0] {
        CHK_MODEL,  // from the local decoder
        CHK_NONE,   // typed: no result
        CHK_ONE     // typed: one result, flagged last
    } row_check_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
        row_check_t chk;
        logic [7:0] exp_value;
        logic [1:0] exp_status;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] value;
        logic [1:0] status;
        logic       last;
    } utf8_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       input_end = 1'b0;
    logic       pop = 1'b0;
    wire        full;
    wire        empty;
    wire  [7:0] out_byte;
    wire  [STATUS_W-1:0] status;
    wire        last;

    json_string_unescape_utf8_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .input_end (input_end),
        .pop       (pop),
        .empty     (empty),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Decoder state
    scan_phase_t  scan_phase = P_IDLE;
    logic [15:0]  hi_unit = 16'h0000;
    logic [15:0]  lo_unit = 16'h0000;
    logic [1:0]   digit_cnt = 2'd0;
    utf8_result_t step_res [4];
    int           step_n;

    utf8_result_t decoded_q [$];
    stim_row_t    feed_q [$];
    int           random_items = 0;
    int           burst_left = 0;
    int           mismatches = 0;
    int           idle_cycles = 0;

    function automatic stim_row_t stim_row(input logic [7:0] data, input logic eoi,
                                           input row_check_t chk, input logic [7:0] value,
                                           input logic [1:0] st);
        stim_row_t r;
        r.data       = data;
        r.eoi        = eoi;
        r.chk        = chk;
        r.exp_value  = value;
        r.exp_status = st;
        return r;
    endfunction

    // Append a row to the stimulus table
    function automatic void add_feed(input stim_row_t r);
        feed_q.insert(feed_q.size(), r);
    endfunction

    // Append one expected result
    function automatic void add_expect(input utf8_result_t e);
        decoded_q.insert(decoded_q.size(), e);
    endfunction

    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
        if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
        if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
        return -1;
    endfunction

    function automatic void emit(input logic [7:0] value, input logic [1:0] st);
        step_res[step_n].value  = value;
        step_res[step_n].status = st;
        step_res[step_n].last   = 1'b0;
        step_n++;
    endfunction

    function automatic void close_literal(input logic [1:0] st);
        scan_phase = P_IDLE;
        digit_cnt  = 2'd0;
        emit(8'h00, st);
    endfunction

    function automatic void encode_cp(input logic [20:0] cp);
        if (cp <= 21'h7F)
        begin
            emit(cp[7:0], ST_BYTE);
        end
        else if (cp <= 21'h7FF)
        begin
            emit({3'b110, cp[10:6]}, ST_BYTE);
            emit({2'b10, cp[5:0]}, ST_BYTE);
        end
        else if (cp <= 21'hFFFF)
        begin
            emit({4'b1110, cp[15:12]}, ST_BYTE);
            emit({2'b10, cp[11:6]}, ST_BYTE);
            emit({2'b10, cp[5:0]}, ST_BYTE);
        end
        else
        begin
            emit({5'b11110, cp[20:18]}, ST_BYTE);
            emit({2'b10, cp[17:12]}, ST_BYTE);
            emit({2'b10, cp[11:6]}, ST_BYTE);
            emit({2'b10, cp[5:0]}, ST_BYTE);
        end
    endfunction

    // Advance the decoder by one input item; results land in step_res
    function automatic void decode_item(input logic [7:0] b, input logic eoi);
        int          d;
        logic [20:0] cp;
        step_n = 0;
        if (eoi)
        begin
            close_literal(ST_ERROR);
        end
        else
        begin
            case (scan_phase)
                P_STR:
                begin
                    if (b == CH_QUOTE) close_literal(ST_DONE);
                    else if (b == CH_BSLASH) scan_phase = P_ESC;
                    else emit(b, ST_BYTE);
                end
                P_ESC:
                begin
                    scan_phase = P_STR;
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: emit(b, ST_BYTE);
                        CH_B: emit(8'h08, ST_BYTE);
                        CH_F: emit(8'h0C, ST_BYTE);
                        CH_N: emit(CH_LF, ST_BYTE);
                        CH_R: emit(CH_CR, ST_BYTE);
                        CH_T: emit(CH_TAB, ST_BYTE);
                        CH_U:
                        begin
                            scan_phase = P_HEX1;
                            hi_unit    = 16'h0000;
                            digit_cnt  = 2'd0;
                        end
                        default: close_literal(ST_ERROR);
                    endcase
                end
                P_HEX1:
                begin
                    d = hex_nibble(b);
                    if (d < 0)
                    begin
                        close_literal(ST_ERROR);
                    end
                    else
                    begin
                        hi_unit = {hi_unit[11:0], d[3:0]};
                        if (digit_cnt != 2'd3)
                        begin
                            digit_cnt++;
                        end
                        else
                        begin
                            digit_cnt = 2'd0;
                            if (hi_unit >= 16'hD800 && hi_unit <= 16'hDBFF)
                            begin
                                scan_phase = P_NEEDBS;
                            end
                            else
                            begin
                                scan_phase = P_STR;
                                encode_cp({5'd0, hi_unit});
                            end
                        end
                    end
                end
                P_NEEDBS:
                begin
                    if (b == CH_BSLASH) scan_phase = P_NEEDU;
                    else close_literal(ST_ERROR);
                end
                P_NEEDU:
                begin
                    if (b == CH_U)
                    begin
                        scan_phase = P_HEX2;
                        lo_unit    = 16'h0000;
                        digit_cnt  = 2'd0;
                    end
                    else
                    begin
                        close_literal(ST_ERROR);
                    end
                end
                P_HEX2:
                begin
                    d = hex_nibble(b);
                    if (d < 0)
                    begin
                        close_literal(ST_ERROR);
                    end
                    else
                    begin
                        lo_unit = {lo_unit[11:0], d[3:0]};
                        if (digit_cnt != 2'd3)
                        begin
                            digit_cnt++;
                        end
                        else
                        begin
                            digit_cnt = 2'd0;
                            if (lo_unit >= 16'hDC00 && lo_unit <= 16'hDFFF)
                            begin
                                cp = 21'h10000 + (21'(hi_unit - 16'hD800) << 10)
                                     + 21'(lo_unit - 16'hDC00);
                                scan_phase = P_STR;
                                encode_cp(cp);
                            end
                            else
                            begin
                                close_literal(ST_ERROR);
                            end
                        end
                    end
                end
                default:
                begin
                    scan_phase = P_IDLE;
                    if (!(b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR))
                    begin
                        if (b == CH_QUOTE) scan_phase = P_STR;
                        else close_literal(ST_ERROR);
                    end
                end
            endcase
        end
        if (step_n > 0) step_res[step_n-1].last = 1'b1;
    endfunction

    // Random literal generation ---------------------------------------------

    function automatic void put_row(input logic [7:0] b, input logic eoi);
        add_feed(stim_row(b, eoi, CHK_MODEL, 8'h00, ST_BYTE));
        random_items++;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic void put_digits(input logic [15:0] u, input int count);
        for (int i = 3; i > 3 - count; i--) put_row(hex_char(u[i*4 +: 4]), 1'b0);
    endfunction

    function automatic void put_unit(input logic [15:0] u);
        put_row(CH_BSLASH, 1'b0);
        put_row(CH_U, 1'b0);
        put_digits(u, 4);
    endfunction

    function automatic logic [15:0] pick_high();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 16'hD800 : 16'hDBFF;
        return 16'($urandom_range(16'hD800, 16'hDBFF));
    endfunction

    function automatic logic [15:0] pick_low();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 16'hDC00 : 16'hDFFF;
        return 16'($urandom_range(16'hDC00, 16'hDFFF));
    endfunction

    function automatic logic [15:0] pick_unit();
        logic [15:0] u;
        case ($urandom_range(0, 4))
            0: u = 16'($urandom_range(0, 16'h7F));
            1: u = 16'($urandom_range(16'h80, 16'h7FF));
            2:
            begin
                do u = 16'($urandom_range(16'h800, 16'hFFFF));
                while (u >= 16'hD800 && u <= 16'hDBFF);
            end
            3: u = pick_low();
            default:
            begin
                case ($urandom_range(0, 5))
                    0: u = 16'h0000;
                    1: u = 16'h007F;
                    2: u = 16'h0080;
                    3: u = 16'h07FF;
                    4: u = 16'h0800;
                    default: u = 16'hFFFF;
                endcase
            end
        endcase
        return u;
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] pick_nonhex();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (hex_nibble(b) >= 0);
        return b;
    endfunction

    // One literal: whitespace, an occasional stray byte or end of input, quote, random content, then a close or a fault
    function automatic void gen_literal();
        logic [7:0]  b;
        logic [15:0] u;
        int          fault;
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 3))
                0: b = CH_SPACE;
                1: b = CH_TAB;
                2: b = CH_LF;
                default: b = CH_CR;
            endcase
            put_row(b, 1'b0);
        end
        if ($urandom_range(0, 11) == 0)
        begin
            do b = 8'($urandom_range(0, 255));
            while (b == CH_QUOTE);
            put_row(b, 1'b0);
        end
        if ($urandom_range(0, 19) == 0) put_row(8'($urandom_range(0, 255)), 1'b1);
        put_row(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 6))
        begin
            case ($urandom_range(0, 6))
                0, 1, 2, 3: put_row(pick_plain(), 1'b0);
                4:
                begin
                    case ($urandom_range(0, 7))
                        0: b = CH_QUOTE;
                        1: b = CH_BSLASH;
                        2: b = CH_SLASH;
                        3: b = CH_B;
                        4: b = CH_F;
                        5: b = CH_N;
                        6: b = CH_R;
                        default: b = CH_T;
                    endcase
                    put_row(CH_BSLASH, 1'b0);
                    put_row(b, 1'b0);
                end
                5: put_unit(pick_unit());
                default:
                begin
                    put_unit(pick_high());
                    put_unit(pick_low());
                end
            endcase
        end
        fault = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        case (fault)
            0: put_row(CH_QUOTE, 1'b0);
            1:
            begin
                do b = 8'($urandom_range(0, 255));
                while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_B ||
                       b == CH_F || b == CH_N || b == CH_R || b == CH_T || b == CH_U);
                put_row(CH_BSLASH, 1'b0);
                put_row(b, 1'b0);
            end
            2:
            begin
                // bad digit in the first unit, or in the low half after a high one
                if ($urandom_range(0, 1)) put_unit(pick_high());
                put_row(CH_BSLASH, 1'b0);
                put_row(CH_U, 1'b0);
                put_digits(16'($urandom), $urandom_range(0, 3));
                put_row(pick_nonhex(), 1'b0);
            end
            3:
            begin
                put_unit(pick_high());
                do b = 8'($urandom_range(0, 255));
                while (b == CH_BSLASH);
                put_row(b, 1'b0);
            end
            4:
            begin
                put_unit(pick_high());
                put_row(CH_BSLASH, 1'b0);
                do b = 8'($urandom_range(0, 255));
                while (b == CH_U);
                put_row(b, 1'b0);
            end
            5:
            begin
                put_unit(pick_high());
                do u = 16'($urandom);
                while (u >= 16'hDC00 && u <= 16'hDFFF);
                put_unit(u);
            end
            default:
            begin
                // cut the payload short in a random phase
                case ($urandom_range(0, 5))
                    1: put_row(CH_BSLASH, 1'b0);
                    2:
                    begin
                        put_row(CH_BSLASH, 1'b0);
                        put_row(CH_U, 1'b0);
                        put_digits(16'($urandom), $urandom_range(0, 3));
                    end
                    3: put_unit(pick_high());
                    4:
                    begin
                        put_unit(pick_high());
                        put_row(CH_BSLASH, 1'b0);
                    end
                    5:
                    begin
                        put_unit(pick_high());
                        put_row(CH_BSLASH, 1'b0);
                        put_row(CH_U, 1'b0);
                        put_digits(16'($urandom), $urandom_range(0, 3));
                    end
                    default: ;
                endcase
                put_row(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
    endfunction

    // Input side ------------------------------------------------------------

    task automatic transfer_row(input stim_row_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        push      <= 1'b1;
        data_byte <= r.data;
        input_end <= r.eoi;
        @(posedge clk);
        while (full) @(posedge clk);
        decode_item(r.data, r.eoi);
        case (r.chk)
            CHK_MODEL: for (int i = 0; i < step_n; i++) add_expect(step_res[i]);
            CHK_ONE:   add_expect({r.exp_value, r.exp_status, 1'b1});
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Hold the input until every expected result has been popped
    task automatic drain_outputs();
        push <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        @(negedge clk);
        burst_left = 0;
    endtask

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_feed(stim_row(CH_SPACE,  1'b0, CHK_NONE,  8'h00, ST_BYTE));
        add_feed(stim_row(8'hFF,     1'b0, CHK_ONE,   8'h00, ST_ERROR));
        add_feed(stim_row(8'h00,     1'b1, CHK_ONE,   8'h00, ST_ERROR));
        add_feed(stim_row(CH_QUOTE,  1'b0, CHK_NONE,  8'h00, ST_BYTE));
        add_feed(stim_row(8'h00,     1'b0, CHK_ONE,   8'h00, ST_BYTE));
        add_feed(stim_row(8'hFF,     1'b0, CHK_ONE,   8'hFF, ST_BYTE));
        // high surrogate with mixed-case digits, joined with its low half
        add_feed(stim_row(CH_BSLASH, 1'b0, CHK_MODEL, 8'h00, ST_BYTE));
        add_feed(stim_row(CH_U,      1'b0, CHK_MODEL, 8'h00, ST_BYTE));
        add_feed(stim_row(8'h64,     1'b0, CHK_MODEL, 8'h00, ST_BYTE));
        add_feed(stim_row(8'h38,     1'b0, CHK_MODEL, 8'h00, ST_BYTE));
        add_feed(stim_row(8'h33,     1'b0, CHK_MODEL, 8'h00, ST_BYTE));
        add_feed(stim_row(8'h44,     1'b0, CHK_MODEL, 8'h00, ST_BYTE));
        add_feed(stim_row(CH_BSLASH, 1'b0, CHK_MODEL, 8'h00, ST_BYTE));
        add_feed(stim_row(CH_U,      1'b0, CHK_MODEL, 8'h00, ST_BYTE));
        add_feed(stim_row(8'h44,     1'b0, CHK_MODEL, 8'h00, ST_BYTE));
        add_feed(stim_row(8'h45,     1'b0, CHK_MODEL, 8'h00, ST_BYTE));
        add_feed(stim_row(8'h30,     1'b0, CHK_MODEL, 8'h00, ST_BYTE));
        add_feed(stim_row(8'h30,     1'b0, CHK_MODEL, 8'h00, ST_BYTE));
        // non-hex digit inside a unit escape
        add_feed(stim_row(CH_BSLASH, 1'b0, CHK_NONE,  8'h00, ST_BYTE));
        add_feed(stim_row(CH_U,      1'b0, CHK_NONE,  8'h00, ST_BYTE));
        add_feed(stim_row(8'h67,     1'b0, CHK_ONE,   8'h00, ST_ERROR));
        // unknown escape letter
        add_feed(stim_row(CH_QUOTE,  1'b0, CHK_NONE,  8'h00, ST_BYTE));
        add_feed(stim_row(CH_BSLASH, 1'b0, CHK_NONE,  8'h00, ST_BYTE));
        add_feed(stim_row(8'h78,     1'b0, CHK_ONE,   8'h00, ST_ERROR));
        add_feed(stim_row(CH_QUOTE,  1'b0, CHK_NONE,  8'h00, ST_BYTE));
        add_feed(stim_row(CH_QUOTE,  1'b0, CHK_ONE,   8'h00, ST_DONE));
        add_feed(stim_row(CH_QUOTE,  1'b0, CHK_NONE,  8'h00, ST_BYTE));
        add_feed(stim_row(8'hFF,     1'b1, CHK_ONE,   8'h00, ST_ERROR));

        while (feed_q.size() != 0) transfer_row(feed_q.pop_front());
        drain_outputs();

        while (random_items < RANDOM_ITEMS)
        begin
            gen_literal();
            while (feed_q.size() != 0) transfer_row(feed_q.pop_front());
            if ($urandom_range(0, 9) == 0) drain_outputs();
        end

        push <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Output side -----------------------------------------------------------

    // Stall pattern: runs of free flow, coin flips and long holds
    initial
    begin : consumer
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(8, 60);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    default: pop <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        utf8_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (decoded_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected transfer: expected none, %s %02h %0d %b",
                         $time, "actual byte/status/last", out_byte, status, last);
            end
            else
            begin
                want = decoded_q.pop_front();
                if (out_byte !== want.value || status !== want.status || last !== want.last)
                begin
                    mismatches++;
                    if (out_byte !== want.value)
                        $display("%0t: out_byte expected %02h, actual %02h",
                                 $time, want.value, out_byte);
                    if (status !== want.status)
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, status);
                    if (last !== want.last)
                        $display("%0t: last expected %b, actual %b",
                                 $time, want.last, last);
                end
            end
        end
    end

    // Watchdog --------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(posedge clk);
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_cmd_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8_unit.sv
hdl/jsu_checker.sv
sim/json_string_unescape_utf8_unit_tb.sv
